FILE: rtl/spq_pkg.sv
// shared types and constants for the sorted max-priority queue
// no dependencies; imported by spq_cell and sorted_max_priority_queue_core
package spq_pkg;

  localparam int SPQ_CAPACITY     = 16;
  localparam int SPQ_KEY_BITS     = 16;
  localparam int SPQ_PAYLOAD_BITS = 16;
  localparam int SPQ_OCC_BITS     = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } spq_action_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

FILE: rtl/sorted_max_priority_queue_core.sv
// output: a result word is registered in the output register in the cycle after its input is taken
// throughput: one word per cycle while in_stall is low; every cell compares against the new key in parallel
//   and the whole row shifts in that same cycle
// reset: synchronous active-low rst_n clears the entry count and output valid;
//   cell storage is not reset and is masked by the count
module sorted_max_priority_queue_core #(
  parameter int CAPACITY     = spq_pkg::SPQ_CAPACITY,
  parameter int KEY_BITS     = spq_pkg::SPQ_KEY_BITS,
  parameter int PAYLOAD_BITS = spq_pkg::SPQ_PAYLOAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [KEY_BITS-1:0]              in_key,
  input  logic [PAYLOAD_BITS-1:0]          in_payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [KEY_BITS-1:0]              out_key,
  output logic [PAYLOAD_BITS-1:0]          out_payload,
  output logic [spq_pkg::SPQ_OCC_BITS-1:0] out_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                    in_acc;
  logic                    is_full;
  logic                    is_empty;
  cell_cmd_t               cmd;

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [CW+SPQ_OCC_BITS-1:0] count_ext;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  spq_status_t             out_status_r;
  spq_status_t             out_status_nxt;
  logic [KEY_BITS-1:0]     out_key_r;
  logic [KEY_BITS-1:0]     out_key_nxt;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic [PAYLOAD_BITS-1:0] out_payload_nxt;
  logic [SPQ_OCC_BITS-1:0] out_occ_r;
  logic [SPQ_OCC_BITS-1:0] out_occ_nxt;

  logic                    occ_w     [CAPACITY];
  logic                    gt_w      [CAPACITY];
  logic [KEY_BITS-1:0]     key_w     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];
  logic                    lo_gt_w   [CAPACITY];
  logic [KEY_BITS-1:0]     lo_key_w  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] lo_pay_w  [CAPACITY];
  logic [KEY_BITS-1:0]     hi_key_w  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] hi_pay_w  [CAPACITY];

  // output register parts the two sides; a draining word frees the slot the same cycle
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign cmd.ins = in_acc && (in_action == ACT_INSERT) && !is_full;
  assign cmd.rem = in_acc && (in_action == ACT_REMOVE) && !is_empty;

  // cell 0 holds the largest key; keys descend toward the last cell
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ_w[gi] = (count_r > CW'(gi));

      if (gi == 0) begin : g_first
        assign lo_gt_w[gi]  = 1'b1;
        assign lo_key_w[gi] = '0;
        assign lo_pay_w[gi] = '0;
      end else begin : g_mid_lo
        assign lo_gt_w[gi]  = gt_w[gi-1];
        assign lo_key_w[gi] = key_w[gi-1];
        assign lo_pay_w[gi] = payload_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign hi_key_w[gi] = '0;
        assign hi_pay_w[gi] = '0;
      end else begin : g_mid_hi
        assign hi_key_w[gi] = key_w[gi+1];
        assign hi_pay_w[gi] = payload_w[gi+1];
      end

      spq_cell #(
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (occ_w[gi]),
        .new_key     (in_key),
        .new_payload (in_payload),
        .lo_gt       (lo_gt_w[gi]),
        .lo_key      (lo_key_w[gi]),
        .lo_payload  (lo_pay_w[gi]),
        .hi_key      (hi_key_w[gi]),
        .hi_payload  (hi_pay_w[gi]),
        .gt          (gt_w[gi]),
        .key         (key_w[gi]),
        .payload     (payload_w[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // occupancy is reported modulo 32
  assign count_ext = (CW + SPQ_OCC_BITS)'(count_nxt);

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_occ_nxt     = out_occ_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt   = 1'b1;
      out_key_nxt     = '0;
      out_payload_nxt = '0;
      out_occ_nxt     = count_ext[SPQ_OCC_BITS-1:0];
      case (in_action)
        ACT_INSERT: begin
          out_status_nxt = is_full ? ST_FULL : ST_INSERTED;
        end
        ACT_REMOVE: begin
          if (is_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_status_nxt  = ST_REMOVED;
            out_key_nxt     = key_w[0];
            out_payload_nxt = payload_w[0];
          end
        end
        default: begin
          out_status_nxt = ST_FULL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r  <= out_status_nxt;
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_payload_r;
  assign out_occupancy = out_occ_r;

`ifndef SYNTHESIS
  // entry count never runs past the row length
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an insert into a non-full queue grows the count by one
  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_INSERT) && !is_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  // the two front cells stay in descending key order
  a_front_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[1] |-> (key_w[0] >= key_w[1]))
    else $error("front cells out of order");

  // an empty status always reports zero occupancy and zero data
  a_empty_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EMPTY))
      |-> ((out_occ_r == '0) && (out_key_r == '0) && (out_payload_r == '0)))
    else $error("empty status with nonzero fields");
`endif

endmodule

FILE: rtl/spq_cell.sv
// one storage cell of the priority queue row (key and payload)
// depends on spq_pkg for the cell command struct
module spq_cell #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  spq_pkg::cell_cmd_t      cmd,
  input  logic                    occ,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    lo_gt,
  input  logic [KEY_BITS-1:0]     lo_key,
  input  logic [PAYLOAD_BITS-1:0] lo_payload,
  input  logic [KEY_BITS-1:0]     hi_key,
  input  logic [PAYLOAD_BITS-1:0] hi_payload,
  output logic                    gt,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0]     key_r;
  logic [KEY_BITS-1:0]     key_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [PAYLOAD_BITS-1:0] payload_nxt;

  // strictly larger stored keys stay put, so equal keys end up below the new word
  assign gt = occ && (key_r > new_key);

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (cmd.ins) begin
      if (!gt) begin
        if (lo_gt) begin
          key_nxt     = new_key;
          payload_nxt = new_payload;
        end else begin
          key_nxt     = lo_key;
          payload_nxt = lo_payload;
        end
      end
    end else if (cmd.rem) begin
      key_nxt     = hi_key;
      payload_nxt = hi_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key     = key_r;
  assign payload = payload_r;

endmodule
